// ===== hdl/elias_gamma_stream_decoder_macros.svh =====
// assertion macros for the elias gamma stream decoder
// no dependencies; included by the modules that check their own logic
`ifndef ELIAS_GAMMA_STREAM_DECODER_MACROS_SVH
`define ELIAS_GAMMA_STREAM_DECODER_MACROS_SVH

// property checked on a named clock and reset
`define EGD_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// property checked on the module's clk and rst
`define EGD_ASSERT(label, prop, msg) \
  `EGD_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

// ===== hdl/egd_pkg.sv =====
// shared types and constants for the elias gamma stream decoder
// no dependencies
package egd_pkg;

  localparam int BYTE_W   = 8;
  localparam int NARROW_W = 8;
  localparam int OUT_W    = 32;
  localparam int CNT_W    = 8;

  localparam logic [CNT_W-1:0] RUN_MAX = {CNT_W{1'b1}};

  typedef logic [OUT_W-1:0] egd_value_t;

  // decoder control state carried from byte to byte
  typedef struct packed {
    logic             in_suffix;
    logic [CNT_W-1:0] zero_run;
    logic [CNT_W-1:0] suffix_left;
    logic             lost_high;
  } egd_ctl_t;

endpackage

// ===== hdl/egd_byte_unit.sv =====
// walks the eight bits of one stream byte, msb first, through the gamma decoder
// depends on egd_pkg
module egd_byte_unit #(
  parameter int ACC_W = 32
) (
  input  logic                                      wide_mode,
  input  logic [egd_pkg::BYTE_W-1:0]                byte_in,
  input  egd_pkg::egd_ctl_t                         ctl_cur,
  input  logic [ACC_W-1:0]                          acc_cur,
  output egd_pkg::egd_ctl_t                         ctl_next,
  output logic [ACC_W-1:0]                          acc_next,
  output logic [egd_pkg::BYTE_W-1:0]                res_hit,
  output egd_pkg::egd_value_t [egd_pkg::BYTE_W-1:0] res_value,
  output logic [egd_pkg::BYTE_W-1:0]                res_lost
);
  import egd_pkg::*;

  localparam logic [ACC_W-1:0] NARROW_MASK = ACC_W'({NARROW_W{1'b1}});
  localparam logic [ACC_W-1:0] ACC_ONE     = ACC_W'(1);

  always_comb begin
    egd_ctl_t         ctl;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] keep_mask;
    logic             bit_in;

    ctl       = ctl_cur;
    acc       = acc_cur;
    keep_mask = wide_mode ? {ACC_W{1'b1}} : NARROW_MASK;
    res_hit   = '0;
    res_value = '0;
    res_lost  = '0;

    for (int i = 0; i < BYTE_W; i++) begin
      bit_in = byte_in[BYTE_W-1-i];
      if (!ctl.in_suffix) begin
        if (!bit_in) begin
          if (ctl.zero_run != RUN_MAX) begin
            ctl.zero_run = ctl.zero_run + CNT_W'(1);
          end
        end else if (ctl.zero_run == '0) begin
          // lone one bit is a complete code of value 1
          res_hit[i]   = 1'b1;
          res_value[i] = OUT_W'(1);
        end else begin
          ctl.in_suffix   = 1'b1;
          ctl.suffix_left = ctl.zero_run;
          ctl.zero_run    = '0;
          ctl.lost_high   = 1'b0;
          acc             = ACC_ONE;
        end
      end else begin
        // a one at or above the top kept bit is about to fall off
        if ((acc & ~(keep_mask >> 1)) != '0) begin
          ctl.lost_high = 1'b1;
        end
        acc = {acc[ACC_W-2:0], bit_in} & keep_mask;
        if (ctl.suffix_left != '0) begin
          ctl.suffix_left = ctl.suffix_left - CNT_W'(1);
        end
        if (ctl.suffix_left == '0) begin
          res_hit[i]    = 1'b1;
          res_value[i]  = OUT_W'(acc);
          res_lost[i]   = ctl.lost_high;
          ctl.in_suffix = 1'b0;
          ctl.lost_high = 1'b0;
          acc           = ACC_ONE;
        end
      end
    end

    ctl_next = ctl;
    acc_next = acc;
  end

endmodule

// ===== hdl/elias_gamma_stream_decoder.sv =====
// flow: an accepted byte waits in the input register, is decoded by the byte unit and its
// results go to the result bank once it is free, and out_valid shows while it holds any
// throughput: one byte per cycle while out_stall is low and each byte finishes at most
// one code; one that ends more holds the bank, one result per unstalled cycle till empty
// reset: synchronous, clears the decoder to counting prefix zeros, empties both stages,
// sets wide_mode to 1; depends on egd_pkg, egd_byte_unit and the assertion macros header
module elias_gamma_stream_decoder #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [egd_pkg::BYTE_W-1:0]       in_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [egd_pkg::OUT_W-1:0]        value,
  output logic                             too_long,
  output logic                             last_in_byte
);
  import egd_pkg::*;
  `include "elias_gamma_stream_decoder_macros.svh"

  localparam int ACC_W = (VALUE_WIDTH > OUT_W) ? OUT_W :
                         (VALUE_WIDTH < NARROW_W) ? NARROW_W : VALUE_WIDTH;

  logic                          wide_mode;
  logic                          byte_valid;
  logic [BYTE_W-1:0]             byte_r;
  egd_ctl_t                      ctl;
  egd_ctl_t                      ctl_next;
  logic [ACC_W-1:0]              value_acc;
  logic [ACC_W-1:0]              value_acc_next;
  logic [BYTE_W-1:0]             res_hit;
  egd_value_t [BYTE_W-1:0]       res_value;
  logic [BYTE_W-1:0]             res_lost;
  logic [BYTE_W-1:0]             bank_mask;
  egd_value_t [BYTE_W-1:0]       bank_value;
  logic [BYTE_W-1:0]             bank_lost;
  logic [BYTE_W-1:0]             sel;
  logic                          out_fire;
  logic                          bank_free;
  logic                          process;

  egd_byte_unit #(
    .ACC_W(ACC_W)
  ) u_byte_unit (
    .wide_mode (wide_mode),
    .byte_in   (byte_r),
    .ctl_cur   (ctl),
    .acc_cur   (value_acc),
    .ctl_next  (ctl_next),
    .acc_next  (value_acc_next),
    .res_hit   (res_hit),
    .res_value (res_value),
    .res_lost  (res_lost)
  );

  // oldest pending result is the lowest set bank bit
  assign sel       = bank_mask & (~bank_mask + BYTE_W'(1));
  assign out_valid = (bank_mask != '0);
  assign out_fire  = out_valid && !out_stall;
  assign bank_free = (bank_mask == '0) || (out_fire && ((bank_mask & ~sel) == '0));
  assign process   = byte_valid && bank_free;
  assign in_stall  = byte_valid && !bank_free;

  always_comb begin
    value        = '0;
    too_long     = 1'b0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (sel[i]) begin
        value    = value | bank_value[i];
        too_long = too_long | bank_lost[i];
      end
    end
    last_in_byte = out_valid && ((bank_mask & ~sel) == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
    end else if (cfg_we) begin
      wide_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= '0;
      value_acc <= ACC_W'(1);
      bank_mask <= '0;
    end else if (process) begin
      ctl       <= ctl_next;
      value_acc <= value_acc_next;
      bank_mask <= res_hit;
    end else if (out_fire) begin
      bank_mask <= bank_mask & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      bank_value <= res_value;
      bank_lost  <= res_lost;
    end
  end

  `EGD_ASSERT(a_suffix_count, ctl.in_suffix == (ctl.suffix_left != '0), "suffix count out of step")
  `EGD_ASSERT(a_prefix_clean, !ctl.in_suffix |-> (value_acc == ACC_W'(1)) && !ctl.lost_high, "acc not reset between codes")
  `EGD_ASSERT(a_stall_held, in_stall |-> byte_valid, "input stalled with nothing held")
  `EGD_ASSERT(a_drain_one, out_fire && !process |=> $countones(bank_mask) == $countones($past(bank_mask)) - 1, "bank lost or kept a result")

endmodule

// ===== tb/sv/elias_gamma_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for elias_gamma_stream_decoder: coded byte streams in, decoded values
// compared against an in-bench gamma decoder; depends on egd_pkg and the decoder rtl
module elias_gamma_stream_decoder_tb;
  import egd_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAX_PRINTED  = 20;

  typedef enum int {FILL_ZEROS, FILL_ONES, FILL_RANDOM} suffix_fill_e;

  typedef struct packed {
    egd_value_t value;
    logic       too_long;
    logic       last_in_byte;
  } gamma_code_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  egd_value_t        value;
  logic              too_long;
  logic              last_in_byte;

  // decoder state mirrored in the bench
  logic              mode_wide = 1'b1;
  logic              dec_in_suffix = 1'b0;
  logic [CNT_W-1:0]  dec_zero_run = '0;
  logic [CNT_W-1:0]  dec_suffix_left = '0;
  egd_value_t        dec_acc = 1;
  logic              dec_lost = 1'b0;

  gamma_code_t       pending_codes[$];
  logic              stream_bits[$];
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                hold_len = 0;
  int                bytes_sent = 0;
  int                mismatches = 0;
  int                cycle_count = 0;

  elias_gamma_stream_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .too_long     (too_long),
    .last_in_byte (last_in_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall plus a counted hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_len <= hold_len - 1;
    end
    out_stall <= (hold_len != 0) || ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input egd_value_t got,
                                 input egd_value_t want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    end
  endtask

  always @(posedge clk) begin : check_results
    gamma_code_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("result with nothing pending, value", value, 0);
      end else begin
        want = pending_codes.pop_front();
        if (value !== want.value)
          report_mismatch("value", value, want.value);
        if (too_long !== want.too_long)
          report_mismatch("too_long", too_long, want.too_long);
        if (last_in_byte !== want.last_in_byte)
          report_mismatch("last_in_byte", last_in_byte, want.last_in_byte);
      end
    end
  end

  // walk one byte msb first and queue every code it completes
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    gamma_code_t found [8];
    egd_value_t  mask;
    logic        b_in;
    int          n;
    int          i;
    n = 0;
    for (i = BYTE_W - 1; i >= 0; i--) begin
      b_in = b[i];
      if (!dec_in_suffix) begin
        if (!b_in) begin
          if (dec_zero_run != RUN_MAX) dec_zero_run++;
        end else if (dec_zero_run == 0) begin
          found[n].value = 1;
          found[n].too_long = 1'b0;
          found[n].last_in_byte = 1'b0;
          n++;
        end else begin
          dec_in_suffix = 1'b1;
          dec_suffix_left = dec_zero_run;
          dec_zero_run = '0;
          dec_acc = 1;
          dec_lost = 1'b0;
        end
      end else begin
        mask = mode_wide ? '1 : egd_value_t'((1 << NARROW_W) - 1);
        if ((dec_acc & ~(mask >> 1)) != 0) dec_lost = 1'b1;
        dec_acc = ((dec_acc << 1) | egd_value_t'(b_in)) & mask;
        if (dec_suffix_left != 0) dec_suffix_left--;
        if (dec_suffix_left == 0) begin
          found[n].value = dec_acc;
          found[n].too_long = dec_lost;
          found[n].last_in_byte = 1'b0;
          n++;
          dec_in_suffix = 1'b0;
          dec_acc = 1;
          dec_lost = 1'b0;
        end
      end
    end
    if (n > 0) found[n-1].last_in_byte = 1'b1;
    for (i = 0; i < n; i++) pending_codes.push_back(found[i]);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    // bytes that finish no code may still be inside the block
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic wide);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= wide;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_wide = wide;
  endtask

  task automatic append_code(input int zeros, input int suffix_len, input suffix_fill_e fill);
    int i;
    for (i = 0; i < zeros; i++) stream_bits.push_back(1'b0);
    stream_bits.push_back(1'b1);
    for (i = 0; i < suffix_len; i++) begin
      case (fill)
        FILL_ZEROS: stream_bits.push_back(1'b0);
        FILL_ONES:  stream_bits.push_back(1'b1);
        default:    stream_bits.push_back(logic'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic append_random_code();
    int pick;
    int top;
    int zeros;
    pick = $urandom_range(0, 99);
    top  = mode_wide ? OUT_W - 1 : NARROW_W - 1;
    if (pick < 35) zeros = $urandom_range(0, 2);
    else if (pick < 75) zeros = $urandom_range(3, mode_wide ? 12 : 5);
    else if (pick < 93) zeros = $urandom_range(0, top);
    else zeros = $urandom_range(top + 1, top + 9);
    append_code(zeros, zeros, ($urandom_range(0, 9) < 2) ? FILL_ONES : FILL_RANDOM);
  endtask

  // pad with ones, each a lone code of value 1, so the stream fills whole bytes
  task automatic send_stream(input int max_bytes, input logic pad_ones);
    logic [BYTE_W-1:0] b;
    int                k;
    int                sent;
    sent = 0;
    if (pad_ones) begin
      while (stream_bits.size() % BYTE_W != 0) stream_bits.push_back(1'b1);
    end
    while (stream_bits.size() >= BYTE_W && sent < max_bytes) begin
      for (k = BYTE_W - 1; k >= 0; k--) b[k] = stream_bits.pop_front();
      send_byte(b);
      sent++;
    end
  endtask

  task automatic test_wide_codes();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    append_code(OUT_W - 1, OUT_W - 1, FILL_ONES);
    append_code(OUT_W, OUT_W, FILL_RANDOM);
    append_code(5, 5, FILL_ZEROS);
    send_stream(100, 1'b1);
    wait_drained();
  endtask

  task automatic test_narrow_codes();
    write_mode(1'b0);
    append_code(NARROW_W - 1, NARROW_W - 1, FILL_ONES);
    append_code(NARROW_W, NARROW_W, FILL_ZEROS);
    append_code(3, 3, FILL_RANDOM);
    send_stream(100, 1'b1);
    wait_drained();
  endtask

  // switch width with a code half read, both directions
  task automatic test_mode_switch();
    append_code(12, 12, FILL_ONES);
    send_stream(2, 1'b0);
    write_mode(1'b1);
    send_stream(8, 1'b1);
    append_code(20, 20, FILL_ONES);
    send_stream(3, 1'b0);
    write_mode(1'b0);
    send_stream(8, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input logic wide, input int idle_pct, input int stall,
                                     input int n_bytes);
    int first;
    write_mode(wide);
    send_idle_pct = idle_pct;
    stall_pct <= stall;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      if ($urandom_range(0, 99) < 15) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        append_random_code();
        send_stream(1000, 1'b0);
      end
    end
    send_stream(1000, 1'b1);
    wait_drained();
    send_idle_pct = 0;
    stall_pct <= 0;
  endtask

  // receiver holds off while dense bytes keep coming, so the input side must stall
  task automatic test_backpressure();
    int i;
    write_mode(1'b1);
    hold_len <= HOLD_CYCLES;
    for (i = 0; i < 12; i++) begin
      send_byte(BYTE_W'($urandom_range(0, 255) | $urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  // zero run past the counter limit, then the full 255-bit suffix
  task automatic test_saturated_run();
    write_mode(1'b1);
    append_code(int'(RUN_MAX) + 1, int'(RUN_MAX), FILL_RANDOM);
    send_stream(1000, 1'b1);
    wait_drained();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("elias_gamma_stream_decoder_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_wide_codes();
    test_narrow_codes();
    test_mode_switch();
    test_random_traffic(1'b1, 0, 0, 5);
    test_random_traffic(1'b0, 80, 0, 5);
    test_random_traffic(1'b1, 0, 80, 5);
    test_random_traffic(1'b0, 9, 9, 5);
    test_backpressure();
    test_saturated_run();
    wait_drained();
    if (mismatches == 0) begin
      $display("elias_gamma_stream_decoder_tb OK");
    end else begin
      $display("elias_gamma_stream_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
